[hdl/min_tracking_stack_unit_macros.svh]
// ----------------------------------------------------------------------------
// min_tracking_stack_unit_macros
// Assertion macros shared by the checker of the stack unit.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_UNIT_MACROS_SVH
`define MIN_TRACKING_STACK_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stack unit assertion failed");

// Next-cycle implication, disabled while reset is held.
`define MTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stack unit assertion failed");

`endif

[hdl/mts_pkg.sv]
// ----------------------------------------------------------------------------
// mts_pkg
// Types and codes shared by the controller and datapath of the stack unit.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int DATA_W = 32;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // a request beat is taken this cycle
        logic finish_pop;  // registered read data holds the new top
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_ok;      // the offered request is a pop of a non-empty stack
    } t_dp_stat;

endpackage

[hdl/mts_datapath.sv]
// ----------------------------------------------------------------------------
// mts_datapath
// Entry memory, cached top entry, fill count and result registers.
// ----------------------------------------------------------------------------
module mts_datapath import mts_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctl_cmd                 i_cmd,
    output t_dp_stat                 o_stat,
    input  logic                     i_req_type,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_popped_value,
    output logic signed [DATA_W-1:0] o_top_value,
    output logic signed [DATA_W-1:0] o_min_value,
    output logic                     o_is_empty,
    output logic [1:0]               o_status
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Each word holds a value and the minimum of it and all entries below.
    logic [2*DATA_W-1:0] mem [DEPTH];
    logic [2*DATA_W-1:0] r_rd_data;

    logic [CNT_W-1:0]         r_fill,     n_fill;
    logic signed [DATA_W-1:0] r_top_val,  n_top_val;
    logic signed [DATA_W-1:0] r_top_min,  n_top_min;

    logic                     r_done,     n_done;
    logic signed [DATA_W-1:0] r_popped,   n_popped;
    logic signed [DATA_W-1:0] r_out_top,  n_out_top;
    logic signed [DATA_W-1:0] r_out_min,  n_out_min;
    logic                     r_empty,    n_empty;
    t_status                  r_status,   n_status;

    logic                     is_pop;
    logic                     full;
    logic                     push_ok;
    logic signed [DATA_W-1:0] push_min;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;
    logic [CNT_W-1:0]         rd_cnt;
    logic signed [DATA_W-1:0] rd_val;
    logic signed [DATA_W-1:0] rd_min;

    assign is_pop  = (i_req_type == REQ_POP);
    assign full    = (r_fill == CNT_W'(DEPTH));
    assign push_ok = !is_pop && !full;
    assign o_stat.pop_ok = is_pop && (r_fill != '0);

    assign push_min = ((r_fill == '0) || (i_push_value < r_top_min)) ? i_push_value
                                                                      : r_top_min;
    assign wr_addr  = r_fill[ADDR_W-1:0];
    // After a pop the new top sits two below the old fill count.
    assign rd_cnt   = r_fill - CNT_W'(2);
    assign rd_addr  = rd_cnt[ADDR_W-1:0];
    assign rd_val   = r_rd_data[2*DATA_W-1:DATA_W];
    assign rd_min   = r_rd_data[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && push_ok) begin
            mem[wr_addr] <= {i_push_value, push_min};
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_fill    = r_fill;
        n_top_val = r_top_val;
        n_top_min = r_top_min;
        n_done    = 1'b0;
        n_popped  = r_popped;
        n_out_top = r_out_top;
        n_out_min = r_out_min;
        n_empty   = r_empty;
        n_status  = r_status;
        if (i_cmd.accept) begin
            n_status = ST_OK;
            n_popped = '0;
            if (o_stat.pop_ok) begin
                // Result goes out once the new top has been read back.
                n_popped = r_top_val;
                n_fill   = r_fill - CNT_W'(1);
            end else begin
                n_done = 1'b1;
                if (push_ok) begin
                    n_fill    = r_fill + CNT_W'(1);
                    n_top_val = i_push_value;
                    n_top_min = push_min;
                    n_out_top = i_push_value;
                    n_out_min = push_min;
                    n_empty   = 1'b0;
                end else begin
                    n_status  = is_pop ? ST_UNDERFLOW : ST_OVERFLOW;
                    n_empty   = (r_fill == '0);
                    n_out_top = (r_fill == '0) ? '0 : r_top_val;
                    n_out_min = (r_fill == '0) ? '0 : r_top_min;
                end
            end
        end else if (i_cmd.finish_pop) begin
            n_done    = 1'b1;
            n_top_val = rd_val;
            n_top_min = rd_min;
            n_empty   = (r_fill == '0);
            n_out_top = (r_fill == '0) ? '0 : rd_val;
            n_out_min = (r_fill == '0) ? '0 : rd_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_done <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_val <= n_top_val;
        r_top_min <= n_top_min;
        r_popped  <= n_popped;
        r_out_top <= n_out_top;
        r_out_min <= n_out_min;
        r_empty   <= n_empty;
        r_status  <= n_status;
    end

    assign o_done         = r_done;
    assign o_popped_value = r_popped;
    assign o_top_value    = r_out_top;
    assign o_min_value    = r_out_min;
    assign o_is_empty     = r_empty;
    assign o_status       = r_status;

endmodule

[hdl/mts_controller.sv]
// ----------------------------------------------------------------------------
// mts_controller
// Sequencer: takes request beats and waits out the memory read of a pop.
// ----------------------------------------------------------------------------
module mts_controller import mts_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd.accept     = 1'b0;
        o_cmd.finish_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.pop_ok) begin
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                o_cmd.finish_pop = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

[hdl/min_tracking_stack_unit.sv]
// ----------------------------------------------------------------------------
// min_tracking_stack_unit
// Bounded signed stack that reports the minimum of the held values.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Signals
//  request   start high, !busy    i_req_type, i_push_value
//  result    o_done, one cycle    o_popped_value, o_top_value, o_min_value,
//                                 o_is_empty, o_status
//
// A push or a rejected request shows its result the cycle after the beat and
// the next beat can be taken in that same cycle. A successful pop holds busy
// in S_POP while the new top comes back through the registered memory read.
// Reset clears the fill count; memory contents need no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module min_tracking_stack_unit import mts_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_req_type,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_popped_value,
    output logic signed [DATA_W-1:0] o_top_value,
    output logic signed [DATA_W-1:0] o_min_value,
    output logic                     o_is_empty,
    output logic [1:0]               o_status
);

    t_ctl_cmd cmd;
    t_dp_stat stat;

    mts_controller u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mts_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_req_type     (i_req_type),
        .i_push_value   (i_push_value),
        .o_done         (o_done),
        .o_popped_value (o_popped_value),
        .o_top_value    (o_top_value),
        .o_min_value    (o_min_value),
        .o_is_empty     (o_is_empty),
        .o_status       (o_status)
    );

endmodule

[hdl/mts_checker.sv]
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks on the stack unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "min_tracking_stack_unit_macros.svh"

module mts_checker import mts_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     i_req_type,
    input logic signed [DATA_W-1:0] i_push_value,
    input logic                     o_done,
    input logic signed [DATA_W-1:0] o_popped_value,
    input logic signed [DATA_W-1:0] o_top_value,
    input logic signed [DATA_W-1:0] o_min_value,
    input logic                     o_is_empty,
    input logic [1:0]               o_status
);

    logic push_beat;
    logic zero_top_min;
    logic none_popped;
    logic st_under;
    logic st_over;

    assign push_beat    = start && !busy && (i_req_type == REQ_PUSH);
    assign zero_top_min = (o_top_value == '0) && (o_min_value == '0);
    assign none_popped  = (o_popped_value == '0);
    assign st_under     = (o_status == ST_UNDERFLOW);
    assign st_over      = (o_status == ST_OVERFLOW);

    // A push beat always answers in the very next cycle.
    `MTS_ASSERT_NXT(a_push_latency, i_clk, i_rst_n, push_beat, o_done)

    // An empty stack reports zero top and zero minimum.
    `MTS_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_done && o_is_empty, zero_top_min)

    // The tracked minimum never exceeds the top value.
    `MTS_ASSERT_IMP(a_min_le_top, i_clk, i_rst_n, o_done && !o_is_empty, o_min_value <= o_top_value)

    // Underflow only on an empty stack and removes nothing.
    `MTS_ASSERT_IMP(a_underflow, i_clk, i_rst_n, o_done && st_under, o_is_empty && none_popped)

    // Overflow only on a full, hence non-empty, stack.
    `MTS_ASSERT_IMP(a_overflow, i_clk, i_rst_n, o_done && st_over, !o_is_empty && none_popped)

endmodule

bind min_tracking_stack_unit mts_checker u_mts_checker (.*);
